FILE: src/eld_pkg.sv
package eld_pkg;

    localparam int CNT_W = 32;
    localparam int RES_DEPTH = 4;
    localparam int RES_AW = $clog2(RES_DEPTH);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_REC  = 2'd1,
        KIND_FILE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INVALID      = 2'd1,
        ST_TOO_LONG     = 2'd2,
        ST_UNTERMINATED = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] num;
        logic [31:0] off;
        t_status     status;
        logic        last;
    } t_result;

endpackage

FILE: src/escaped_line_record_decoder.sv
// Splits a byte stream into LF-terminated records, decoding backslash escapes
// and reporting each record end (number, start offset, status) and the file
// end. A registered input word is decoded combinationally and its zero to two
// results go into a four-entry result queue that drives the output port. One
// input word is taken per cycle while the queue has room for two results; the
// single output port presents one result at a time, so sustained rate is one
// word per cycle only for words with at most one result and a ready output.
// The cap register may be written only while the block is idle.
module escaped_line_record_decoder
    import eld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_record_number,
    output logic [31:0] o_record_offset,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic [15:0]     r_max;
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_eof;
    logic            take;
    logic [1:0]      res_n;
    logic [1:0]      push_n;
    t_result         res0;
    t_result         res1;
    t_result         head;
    logic [RES_AW:0] count;

    assign o_cfg_ready = 1'b1;
    assign take        = r_in_valid && (count <= (RES_AW + 1)'(RES_DEPTH - 2));
    assign o_in_ready  = !r_in_valid || take;
    assign push_n      = take ? res_n : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= 16'd4096;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_file_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    eld_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (take),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .i_max   (r_max),
        .o_n     (res_n),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    eld_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_d0     (res0),
        .i_d1     (res1),
        .i_pop    (i_out_ready),
        .o_valid  (o_out_valid),
        .o_data   (head),
        .o_count  (count)
    );

    assign o_result_kind   = head.kind;
    assign o_data_byte     = head.data;
    assign o_record_number = head.num;
    assign o_record_offset = head.off;
    assign o_status        = head.status;
    assign o_last          = head.last;

endmodule

FILE: src/eld_decode.sv
module eld_decode
    import eld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    input  logic [15:0] i_max,
    output logic [1:0]  o_n,
    output t_result     o_res0,
    output t_result     o_res1
);

    typedef struct packed {
        logic [15:0]      dc;
        logic             esc;
        logic             crh;
        logic             halted;
        logic [CNT_W-1:0] rs;
        logic [CNT_W-1:0] rb;
        logic [1:0]       n;
        t_result          r0;
        t_result          r1;
    } t_work;

    logic [15:0]      r_dc;
    logic             r_esc;
    logic             r_crh;
    logic             r_halted;
    logic [CNT_W-1:0] r_bp;
    logic [CNT_W-1:0] r_rs;
    logic [CNT_W-1:0] r_rb;

    logic [15:0]      n_dc;
    logic             n_esc;
    logic             n_crh;
    logic             n_halted;
    logic [CNT_W-1:0] n_bp;
    logic [CNT_W-1:0] n_rs;
    logic [CNT_W-1:0] n_rb;

    function automatic t_work f_emit(t_work w, t_kind k, logic [7:0] d,
                                     logic [CNT_W-1:0] num, logic [CNT_W-1:0] off,
                                     t_status s);
        t_result r;
        r.kind   = k;
        r.data   = d;
        r.num    = 32'(num);
        r.off    = 32'(off);
        r.status = s;
        r.last   = 1'b0;
        if (w.n == 2'd0) begin
            w.r0 = r;
            w.n  = 2'd1;
        end else if (w.n == 2'd1) begin
            w.r1 = r;
            w.n  = 2'd2;
        end
        return w;
    endfunction

    function automatic t_work f_error_end(t_work w, t_status s);
        w = f_emit(w, KIND_REC, 8'd0, w.rs + 1'b1, w.rb, s);
        w.halted = 1'b1;
        w.esc    = 1'b0;
        w.crh    = 1'b0;
        return w;
    endfunction

    // fails (and halts) when the record is already at the cap
    function automatic t_work f_push(t_work w, logic [7:0] b, logic [15:0] cap);
        if (w.dc == cap) begin
            w = f_error_end(w, ST_TOO_LONG);
        end else begin
            w.dc = w.dc + 16'd1;
            w = f_emit(w, KIND_DATA, b, '0, '0, ST_OK);
        end
        return w;
    endfunction

    function automatic t_work f_record_ok(t_work w, logic [CNT_W-1:0] pos);
        w.rs = w.rs + 1'b1;
        w = f_emit(w, KIND_REC, 8'd0, w.rs, w.rb, ST_OK);
        w.rb = pos + 1'b1;
        w.dc = '0;
        return w;
    endfunction

    function automatic t_work f_plain(t_work w, logic [7:0] b, logic [CNT_W-1:0] pos,
                                      logic [15:0] cap);
        if (b == CH_BSLASH) begin
            w.esc = 1'b1;
        end else if (b == CH_LF) begin
            w = f_record_ok(w, pos);
        end else if (b == CH_CR) begin
            w.crh = 1'b1;
        end else if (b == CH_TAB || b == CH_VT || b == CH_FF) begin
            w = f_push(w, b, cap);
        end else if (b < CH_SPACE || b == CH_DEL) begin
            w = f_error_end(w, ST_INVALID);
        end else begin
            w = f_push(w, b, cap);
        end
        return w;
    endfunction

    t_work w;

    always_comb begin
        w        = '0;
        w.dc     = r_dc;
        w.esc    = r_esc;
        w.crh    = r_crh;
        w.halted = r_halted;
        w.rs     = r_rs;
        w.rb     = r_rb;
        n_bp     = r_bp;

        if (i_eof) begin
            if (!w.halted) begin
                if (w.crh) begin
                    w.crh = 1'b0;
                    w = f_push(w, CH_CR, i_max);
                end else if (w.esc) begin
                    w.esc = 1'b0;
                    w = f_push(w, CH_BSLASH, i_max);
                end
            end
            w = f_emit(w, KIND_FILE, 8'd0, w.rs, w.rb,
                       (!w.halted && r_bp != w.rb) ? ST_UNTERMINATED : ST_OK);
            n_bp = '0;
        end else begin
            n_bp = r_bp + 1'b1;
            if (!w.halted) begin
                if (w.esc) begin
                    w.esc = 1'b0;
                    if (i_byte == CH_N) begin
                        w = f_push(w, CH_LF, i_max);
                    end else if (i_byte == CH_BSLASH) begin
                        w = f_push(w, CH_BSLASH, i_max);
                    end else begin
                        w = f_push(w, CH_BSLASH, i_max);
                        if (!w.halted) begin
                            w = f_push(w, i_byte, i_max);
                        end
                    end
                end else if (w.crh) begin
                    w.crh = 1'b0;
                    if (i_byte == CH_LF) begin
                        w = f_record_ok(w, r_bp);
                    end else begin
                        w = f_push(w, CH_CR, i_max);
                        if (!w.halted) begin
                            w = f_plain(w, i_byte, r_bp, i_max);
                        end
                    end
                end else begin
                    w = f_plain(w, i_byte, r_bp, i_max);
                end
            end
        end

        w.r0.last = (w.n == 2'd1);
        w.r1.last = (w.n == 2'd2);

        if (i_eof) begin
            n_dc     = '0;
            n_esc    = 1'b0;
            n_crh    = 1'b0;
            n_halted = 1'b0;
            n_rs     = '0;
            n_rb     = '0;
        end else begin
            n_dc     = w.dc;
            n_esc    = w.esc;
            n_crh    = w.crh;
            n_halted = w.halted;
            n_rs     = w.rs;
            n_rb     = w.rb;
        end
    end

    assign o_n    = w.n;
    assign o_res0 = w.r0;
    assign o_res1 = w.r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc     <= '0;
            r_esc    <= 1'b0;
            r_crh    <= 1'b0;
            r_halted <= 1'b0;
            r_bp     <= '0;
            r_rs     <= '0;
            r_rb     <= '0;
        end else if (i_step) begin
            r_dc     <= n_dc;
            r_esc    <= n_esc;
            r_crh    <= n_crh;
            r_halted <= n_halted;
            r_bp     <= n_bp;
            r_rs     <= n_rs;
            r_rb     <= n_rb;
        end
    end

endmodule

FILE: src/eld_result_fifo.sv
module eld_result_fifo
    import eld_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_n,
    input  t_result         i_d0,
    input  t_result         i_d1,
    input  logic            i_pop,
    output logic            o_valid,
    output t_result         o_data,
    output logic [RES_AW:0] o_count
);

    t_result          r_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_wp;
    logic [RES_AW-1:0] r_rp;
    logic [RES_AW:0]   r_count;
    logic              pop;
    logic [RES_AW-1:0] wp1;

    assign pop     = i_pop && (r_count != '0);
    assign wp1     = r_wp + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wp1] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + RES_AW'(i_push_n);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (RES_AW + 1)'(i_push_n) - (RES_AW + 1)'(pop);
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import eld_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 100;

    typedef struct packed {
        logic [7:0] b;
        logic       eof;
        logic       typed;
        t_result    want;
    } t_word;

    // directed words; rows with typed set carry their single result by hand
    localparam t_word DIRECTED [0:24] = '{
        '{8'h41, 1'b0, 1'b1, '{KIND_DATA, 8'h41, 32'd0, 32'd0, ST_OK, 1'b1}},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h7e, 1'b0, 1'b0, '0},
        '{8'h5c, 1'b0, 1'b0, '0},
        '{8'h6e, 1'b0, 1'b0, '0},
        '{8'h5c, 1'b0, 1'b0, '0},
        '{8'h5c, 1'b0, 1'b0, '0},
        '{8'h5c, 1'b0, 1'b0, '0},
        '{8'h71, 1'b0, 1'b0, '0},
        '{8'h09, 1'b0, 1'b0, '0},
        '{8'h0b, 1'b0, 1'b0, '0},
        '{8'h0c, 1'b0, 1'b0, '0},
        '{8'h0d, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{8'h0d, 1'b0, 1'b0, '0},
        '{8'h0a, 1'b0, 1'b1, '{KIND_REC, 8'h00, 32'd1, 32'd0, ST_OK, 1'b1}},
        '{8'hff, 1'b0, 1'b0, '0},
        '{8'h5c, 1'b0, 1'b0, '0},
        '{8'h0a, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{KIND_REC, 8'h00, 32'd2, 32'd16, ST_INVALID, 1'b1}},
        '{8'h7f, 1'b0, 1'b0, '0},
        '{8'ha5, 1'b1, 1'b1, '{KIND_FILE, 8'h00, 32'd1, 32'd16, ST_OK, 1'b1}},
        '{8'h7a, 1'b0, 1'b0, '0},
        '{8'h5c, 1'b0, 1'b0, '0},
        '{8'h5a, 1'b1, 1'b0, '0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_file_byte   = '0;
    logic        i_end_of_file = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_record_number;
    logic [31:0] o_record_offset;
    logic [1:0]  o_status;
    logic        o_last;

    // decoder state as the testbench sees it
    logic        esc_pending;
    logic        cr_held;
    logic [15:0] dec_count;
    logic [31:0] byte_pos;
    logic [31:0] rec_begin;
    logic [31:0] rec_count;
    logic        halted;
    logic [15:0] cap;

    t_result     step_res [2];
    int          step_n;
    t_result     pending_results [$];
    t_word       stim_q [$];
    t_word       cur_word = '0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          idle_cycles = 0;

    escaped_line_record_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_file_byte    (i_file_byte),
        .i_end_of_file  (i_end_of_file),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_data_byte    (o_data_byte),
        .o_record_number(o_record_number),
        .o_record_offset(o_record_offset),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void clear_decoder();
        esc_pending = 1'b0;
        cr_held     = 1'b0;
        dec_count   = '0;
        byte_pos    = '0;
        rec_begin   = '0;
        rec_count   = '0;
        halted      = 1'b0;
    endfunction

    function automatic void add_result(t_kind k, logic [7:0] d, logic [31:0] num,
                                       logic [31:0] off, t_status st);
        if (step_n < 2) begin
            step_res[step_n] = '{kind: k, data: d, num: num, off: off, status: st,
                                 last: 1'b0};
            step_n++;
        end
    endfunction

    function automatic void end_with_error(t_status st);
        add_result(KIND_REC, 8'h00, rec_count + 32'd1, rec_begin, st);
        halted      = 1'b1;
        esc_pending = 1'b0;
        cr_held     = 1'b0;
    endfunction

    function automatic bit push_decoded(logic [7:0] d);
        if (dec_count == cap) begin
            end_with_error(ST_TOO_LONG);
            return 1'b0;
        end
        dec_count++;
        add_result(KIND_DATA, d, '0, '0, ST_OK);
        return 1'b1;
    endfunction

    function automatic void close_record(logic [31:0] pos);
        rec_count++;
        add_result(KIND_REC, 8'h00, rec_count, rec_begin, ST_OK);
        rec_begin = pos + 32'd1;
        dec_count = '0;
    endfunction

    function automatic void plain_byte(logic [7:0] b, logic [31:0] pos);
        if (b == CH_BSLASH) begin
            esc_pending = 1'b1;
        end else if (b == CH_LF) begin
            close_record(pos);
        end else if (b == CH_CR) begin
            cr_held = 1'b1;
        end else if ((b < CH_SPACE && b != CH_TAB && b != CH_VT && b != CH_FF)
                     || b == CH_DEL) begin
            end_with_error(ST_INVALID);
        end else begin
            void'(push_decoded(b));
        end
    endfunction

    function automatic void decode_word(logic [7:0] b, logic eof);
        logic [31:0] pos;
        step_n = 0;
        if (eof) begin
            if (!halted) begin
                if (cr_held) begin
                    cr_held = 1'b0;
                    void'(push_decoded(CH_CR));
                end else if (esc_pending) begin
                    esc_pending = 1'b0;
                    void'(push_decoded(CH_BSLASH));
                end
            end
            add_result(KIND_FILE, 8'h00, rec_count, rec_begin,
                       (!halted && byte_pos != rec_begin) ? ST_UNTERMINATED : ST_OK);
            clear_decoder();
        end else begin
            pos = byte_pos;
            byte_pos = pos + 32'd1;
            if (!halted) begin
                if (esc_pending) begin
                    esc_pending = 1'b0;
                    if (b == CH_N) begin
                        void'(push_decoded(CH_LF));
                    end else if (b == CH_BSLASH) begin
                        void'(push_decoded(CH_BSLASH));
                    end else if (push_decoded(CH_BSLASH)) begin
                        void'(push_decoded(b));
                    end
                end else if (cr_held) begin
                    cr_held = 1'b0;
                    if (b == CH_LF) begin
                        close_record(pos);
                    end else if (push_decoded(CH_CR)) begin
                        plain_byte(b, pos);
                    end
                end else begin
                    plain_byte(b, pos);
                end
            end
        end
        if (step_n > 0) begin
            step_res[step_n - 1].last = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_word(logic [7:0] b, logic eof);
        stim_q.push_back('{b: b, eof: eof, typed: 1'b0, want: '0});
    endfunction

    // one file: a few records of mostly printable text with escapes, then end of file
    function automatic void queue_file(logic [15:0] cap_now);
        int n_rec;
        int len;
        int limit;
        int sel;
        logic [7:0] pr;
        n_rec = $urandom_range(1, 6);
        limit = (cap_now > 16'd14) ? 14 : int'(cap_now) + 2;
        for (int r = 0; r < n_rec; r++) begin
            len = $urandom_range(0, limit);
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 8)) add_word(8'($urandom_range(0, 255)), 1'b0);
            end
            repeat (len) begin
                sel = $urandom_range(0, 99);
                pr = 8'($urandom_range(32, 126));
                if (pr == CH_BSLASH) pr = CH_N;
                if (sel < 62) begin
                    add_word(pr, 1'b0);
                end else if (sel < 74) begin
                    add_word(CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 2))
                        0: add_word(CH_N, 1'b0);
                        1: add_word(CH_BSLASH, 1'b0);
                        default: add_word(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end else if (sel < 80) begin
                    add_word(CH_CR, 1'b0);
                    add_word(pr, 1'b0);
                end else if (sel < 86) begin
                    case ($urandom_range(0, 2))
                        0: add_word(CH_TAB, 1'b0);
                        1: add_word(CH_VT, 1'b0);
                        default: add_word(CH_FF, 1'b0);
                    endcase
                end else if (sel < 93) begin
                    add_word(8'($urandom_range(128, 255)), 1'b0);
                end else if (sel < 97) begin
                    add_word(8'($urandom_range(0, 255)), 1'b0);
                end else if ($urandom_range(0, 4) == 0) begin
                    add_word(CH_DEL, 1'b0);
                end else begin
                    add_word(8'($urandom_range(0, 31)), 1'b0);
                end
            end
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                add_word(CH_LF, 1'b0);
            end else if (sel < 16) begin
                add_word(CH_CR, 1'b0);
                add_word(CH_LF, 1'b0);
            end else if (sel == 16) begin
                add_word(CH_BSLASH, 1'b0);
            end else if (sel == 17) begin
                add_word(CH_CR, 1'b0);
            end
        end
        add_word(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    task automatic send_word(input t_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_file_byte   <= w.b;
        i_end_of_file <= w.eof;
        cur_word      <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_cap(input logic [15:0] v);
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] new_cap);
        int sent;
        write_cap(new_cap);
        sent = 0;
        while (sent < PHASE_WORDS) begin
            queue_file(new_cap);
            while (stim_q.size() != 0) begin
                send_word(stim_q.pop_front());
                sent++;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // output pacing, with two long hold-offs to back the block up
    initial begin : out_pacing
        int run;
        int stall;
        int holds_done;
        holds_done = 0;
        forever begin
            if (holds_done < 2 && results_checked >= (holds_done == 0 ? 150 : 500)) begin
                holds_done++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                i_out_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        logic moved;
        if (!i_rst_n) begin
            clear_decoder();
            cap = 16'd4096;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                cap = i_cfg_data;
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                decode_word(i_file_byte, i_end_of_file);
                if (cur_word.typed) begin
                    pending_results.push_back(cur_word.want);
                end else begin
                    for (int k = 0; k < step_n; k++) pending_results.push_back(step_res[k]);
                end
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{kind: t_kind'(o_result_kind), data: o_data_byte,
                        num: o_record_number, off: o_record_offset,
                        status: t_status'(o_status), last: o_last};
                results_checked++;
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, expected none, got %h",
                             $time, got);
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("data_byte", want.data, got.data);
                    check_field("record_number", want.num, got.num);
                    check_field("record_offset", want.off, got.off);
                    check_field("status", want.status, got.status);
                    check_field("last", want.last, got.last);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[k]) send_word(DIRECTED[k]);
        i_in_valid <= 1'b0;
        run_phase(16'd1);
        run_phase(16'd65535);
        run_phase(16'd3);
        run_phase(16'($urandom_range(2, 12)));
        run_phase(16'($urandom_range(1, 65535)));
        run_phase(16'd4096);
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
